@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the pose track statistics block.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned CELL_MM_DEF   = 250;
  localparam int unsigned GRID_SIDE_DEF = 64;
  localparam logic [15:0] RESET_JUMP_DEF = 16'd1000;

  // Both the square roots and the cell divisions run this many steps.
  localparam int unsigned ITER_STEPS = 18;
  localparam int unsigned CNT_W      = $clog2(ITER_STEPS);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SQ_LX,
    ST_SQ_LY,
    ST_SQ_JUMP,
    ST_CHECK,
    ST_SQ_DX,
    ST_SQ_DY,
    ST_SQ_SX,
    ST_SQ_SY,
    ST_LOAD,
    ST_ITER_CELL,
    ST_LOAD_MOD,
    ST_ITER_MOD,
    ST_MEM_RD,
    ST_UPDATE,
    ST_EMIT
  } pts_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LX,
    MUL_LY,
    MUL_JUMP,
    MUL_DX,
    MUL_DY,
    MUL_SX,
    MUL_SY
  } pts_mul_e;

  typedef struct packed {
    logic     capture;
    logic     new_session;
    logic     clr_step;
    pts_mul_e mul;
    logic     check;
    logic     load_iter;
    logic     load_mod;
    logic     iter;
    logic     mod_phase;
    logic     mem_rd;
    logic     update;
    logic     load_out;
  } pts_cmd_t;

  typedef struct packed {
    logic kind;
    logic drop_hit;
    logic clr_last;
  } pts_status_t;

endpackage

@@ rtl/pose_track_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_track_statistics
// Session statistics over robot pose samples.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. A pose sample passes from
// acceptance to result through seven squarings on one shared multiplier, 18
// steps of the paired root and cell-divider lanes, 18 steps of the grid
// modulo, a map read and an update; a dropped sample returns after the check.
// After a pose sample the next word can be taken in the cycle after the result
// is loaded, so a new pose sample is taken only once the last one's result is
// loaded, which waits while the result side stalls. A new-session word goes
// from decode straight to its result and is followed by a walk that clears
// the visited map, GRID_SIDE * GRID_SIDE cells (4096 by default); the same
// walk runs after reset. No word is taken during either.
// The configuration register may be written at any time the block is idle.
module pose_track_statistics #(
  parameter int unsigned CELL_MM   = pts_pkg::CELL_MM_DEF,
  parameter int unsigned GRID_SIDE = pts_pkg::GRID_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_kind_i,
  input  logic signed [15:0] in_pos_x_i,
  input  logic signed [15:0] in_pos_y_i,
  input  logic signed [12:0] in_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_dropped_o,
  output logic [31:0]        out_distance_total_o,
  output logic [31:0]        out_rotation_total_o,
  output logic [16:0]        out_farthest_from_start_o,
  output logic [12:0]        out_cells_visited_o,
  output logic [31:0]        out_samples_taken_o
);
  import pts_pkg::*;

  pts_cmd_t    cmd;
  pts_status_t status;

  assign cfg_ready_o = 1'b1;

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pts_datapath #(
    .CELL_MM   (CELL_MM),
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cmd_i                     (cmd),
    .status_o                  (status),
    .cfg_valid_i               (cfg_valid_i),
    .cfg_wdata_i               (cfg_wdata_i),
    .in_kind_i                 (in_kind_i),
    .in_pos_x_i                (in_pos_x_i),
    .in_pos_y_i                (in_pos_y_i),
    .in_heading_i              (in_heading_i),
    .out_dropped_o             (out_dropped_o),
    .out_distance_total_o      (out_distance_total_o),
    .out_rotation_total_o      (out_rotation_total_o),
    .out_farthest_from_start_o (out_farthest_from_start_o),
    .out_cells_visited_o       (out_cells_visited_o),
    .out_samples_taken_o       (out_samples_taken_o)
  );

endmodule

@@ rtl/pts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: steps the datapath through one word and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pts_pkg::pts_status_t status_i,
  output pts_pkg::pts_cmd_t   cmd_o
);
  import pts_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER_STEPS - 1);

  pts_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             accept;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:      if (accept) state_d = ST_DECODE;
      ST_DECODE:    state_d = status_i.kind ? ST_EMIT : ST_SQ_LX;
      ST_SQ_LX:     state_d = ST_SQ_LY;
      ST_SQ_LY:     state_d = ST_SQ_JUMP;
      ST_SQ_JUMP:   state_d = ST_CHECK;
      ST_CHECK:     state_d = status_i.drop_hit ? ST_EMIT : ST_SQ_DX;
      ST_SQ_DX:     state_d = ST_SQ_DY;
      ST_SQ_DY:     state_d = ST_SQ_SX;
      ST_SQ_SX:     state_d = ST_SQ_SY;
      ST_SQ_SY:     state_d = ST_LOAD;
      ST_LOAD:      state_d = ST_ITER_CELL;
      ST_ITER_CELL: if (cnt_q == CNT_LAST) state_d = ST_LOAD_MOD;
      ST_LOAD_MOD:  state_d = ST_ITER_MOD;
      ST_ITER_MOD:  if (cnt_q == CNT_LAST) state_d = ST_MEM_RD;
      ST_MEM_RD:    state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_d = status_i.kind ? ST_CLEAR : ST_IDLE;
      end
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul   = MUL_NONE;
    cnt_d       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_CLEAR:     cmd_o.clr_step = 1'b1;
      ST_IDLE:      cmd_o.capture = accept;
      ST_DECODE:    cmd_o.new_session = status_i.kind;
      ST_SQ_LX:     cmd_o.mul = MUL_LX;
      ST_SQ_LY:     cmd_o.mul = MUL_LY;
      ST_SQ_JUMP:   cmd_o.mul = MUL_JUMP;
      ST_CHECK:     cmd_o.check = 1'b1;
      ST_SQ_DX:     cmd_o.mul = MUL_DX;
      ST_SQ_DY:     cmd_o.mul = MUL_DY;
      ST_SQ_SX:     cmd_o.mul = MUL_SX;
      ST_SQ_SY:     cmd_o.mul = MUL_SY;
      ST_LOAD:      cmd_o.load_iter = 1'b1;
      ST_ITER_CELL: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
      end
      ST_LOAD_MOD:  cmd_o.load_mod = 1'b1;
      ST_ITER_MOD: begin
        cmd_o.iter      = 1'b1;
        cmd_o.mod_phase = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
      end
      ST_MEM_RD:    cmd_o.mem_rd = 1'b1;
      ST_UPDATE:    cmd_o.update = 1'b1;
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/pts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_datapath
// Session registers, shared squarer, two root lanes, two cell divider lanes
// and the visited-cell map.
// ----------------------------------------------------------------------------
module pts_datapath #(
  parameter int unsigned CELL_MM   = pts_pkg::CELL_MM_DEF,
  parameter int unsigned GRID_SIDE = pts_pkg::GRID_SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pts_pkg::pts_cmd_t    cmd_i,
  output pts_pkg::pts_status_t status_o,
  input  logic                 cfg_valid_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_kind_i,
  input  logic signed [15:0]   in_pos_x_i,
  input  logic signed [15:0]   in_pos_y_i,
  input  logic signed [12:0]   in_heading_i,
  output logic                 out_dropped_o,
  output logic [31:0]          out_distance_total_o,
  output logic [31:0]          out_rotation_total_o,
  output logic [16:0]          out_farthest_from_start_o,
  output logic [12:0]          out_cells_visited_o,
  output logic [31:0]          out_samples_taken_o
);
  import pts_pkg::*;

  localparam int unsigned MAP_BITS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW       = $clog2(MAP_BITS);
  localparam int unsigned CW       = $clog2(GRID_SIDE);
  // Offset that makes every coordinate non-negative before dividing.
  localparam int unsigned KOFF     = (32768 + CELL_MM - 1) / CELL_MM;
  localparam int unsigned KM       = KOFF * CELL_MM;
  localparam int unsigned MODC     = (GRID_SIDE - (KOFF % GRID_SIDE)) % GRID_SIDE;
  localparam int unsigned DIV_W    = 18;
  localparam int unsigned DREM_W   = 13;
  localparam int unsigned SQ_W     = 34;
  localparam int unsigned RAD_W    = 36;
  localparam int unsigned SREM_W   = 20;
  localparam int unsigned ROOT_W   = 18;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    abs17 = v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add32 = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [15:0]        jump_q;
  logic               kind_q;
  logic signed [15:0] x_q, y_q, last_x_q, last_y_q, start_x_q, start_y_q;
  logic signed [12:0] h_q, last_h_q;
  logic               have_prev_q, drop_q;
  logic [31:0]        path_q, turn_q, samples_q;
  logic [16:0]        far_q;
  logic [12:0]        cells_q;
  logic [SQ_W-1:0]    step_sq_q, start_sq_q;

  logic [ROOT_W-1:0]  root_q [2];
  logic [SREM_W-1:0]  srem_q [2];
  logic [RAD_W-1:0]   rad_q  [2];
  logic [DIV_W-1:0]   dvd_q  [2];
  logic [DREM_W-1:0]  drem_q [2];

  logic               mem_q [MAP_BITS];
  logic               rd_q;
  logic [AW-1:0]      clr_addr_q;

  // Squarer operand.
  logic signed [15:0] sx_eff, sy_eff;
  logic [16:0]        opnd;
  logic [SQ_W-1:0]    prod;

  assign sx_eff = have_prev_q ? start_x_q : x_q;
  assign sy_eff = have_prev_q ? start_y_q : y_q;

  always_comb begin
    case (cmd_i.mul)
      MUL_LX:   opnd = abs17(17'(last_x_q));
      MUL_LY:   opnd = abs17(17'(last_y_q));
      MUL_JUMP: opnd = {1'b0, jump_q};
      MUL_DX:   opnd = abs17(17'(x_q) - 17'(last_x_q));
      MUL_DY:   opnd = abs17(17'(y_q) - 17'(last_y_q));
      MUL_SX:   opnd = abs17(17'(x_q) - 17'(sx_eff));
      MUL_SY:   opnd = abs17(17'(y_q) - 17'(sy_eff));
      default:  opnd = '0;
    endcase
  end

  assign prod = SQ_W'(opnd) * SQ_W'(opnd);

  // One step of each root lane and each divider lane.
  logic [SREM_W-1:0] srem_n [2];
  logic [SREM_W-1:0] trial  [2];
  logic [DREM_W-1:0] drem_n [2];
  logic [DREM_W-1:0] divisor;
  logic              sbit [2];
  logic              qbit [2];

  assign divisor = cmd_i.mod_phase ? DREM_W'(GRID_SIDE) : DREM_W'(CELL_MM);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      srem_n[i] = {srem_q[i][SREM_W-3:0], rad_q[i][RAD_W-1 -: 2]};
      trial[i]  = {root_q[i], 2'b01};
      sbit[i]   = (srem_n[i] >= trial[i]);
      drem_n[i] = {drem_q[i][DREM_W-2:0], dvd_q[i][DIV_W-1]};
      qbit[i]   = (drem_n[i] >= divisor);
    end
  end

  // Heading change, wrapped once.
  logic signed [13:0] dh, dh_w;
  logic [13:0]        dh_abs;

  always_comb begin
    dh = 14'(h_q) - 14'(last_h_q);
    dh_w = dh;
    if (dh_w > 14'sd1800)  dh_w = dh_w - 14'sd3600;
    if (dh_w < -14'sd1800) dh_w = dh_w + 14'sd3600;
    dh_abs = dh_w[13] ? 14'(-dh_w) : 14'(dh_w);
  end

  logic [CW-1:0] cx, cy;
  logic [AW-1:0] cell_addr;
  logic [16:0]   dist_start;

  assign cx         = drem_q[0][CW-1:0];
  assign cy         = drem_q[1][CW-1:0];
  assign cell_addr  = AW'(int'(cy) * GRID_SIDE + int'(cx));
  assign dist_start = root_q[1][16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q      <= RESET_JUMP_DEF;
      have_prev_q <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_h_q    <= '0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      path_q      <= '0;
      turn_q      <= '0;
      far_q       <= '0;
      cells_q     <= '0;
      samples_q   <= '0;
      clr_addr_q  <= '0;
    end else begin
      if (cfg_valid_i) jump_q <= cfg_wdata_i;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
      if (cmd_i.new_session) begin
        have_prev_q <= 1'b0;
        last_x_q    <= '0;
        last_y_q    <= '0;
        last_h_q    <= '0;
        start_x_q   <= '0;
        start_y_q   <= '0;
        path_q      <= '0;
        turn_q      <= '0;
        far_q       <= '0;
        cells_q     <= '0;
        samples_q   <= '0;
        clr_addr_q  <= '0;
      end
      if (cmd_i.update) begin
        have_prev_q <= 1'b1;
        if (!have_prev_q) begin
          start_x_q <= x_q;
          start_y_q <= y_q;
        end else begin
          path_q <= sat_add32(path_q, 32'(root_q[0]));
          turn_q <= sat_add32(turn_q, 32'(dh_abs));
        end
        last_x_q <= x_q;
        last_y_q <= y_q;
        last_h_q <= h_q;
        if (dist_start > far_q) far_q <= dist_start;
        if (!rd_q && cells_q != 13'h1FFF) cells_q <= cells_q + 13'd1;
        samples_q <= sat_add32(samples_q, 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      x_q    <= in_pos_x_i;
      y_q    <= in_pos_y_i;
      h_q    <= in_heading_i;
      drop_q <= 1'b0;
    end
    if (cmd_i.check) drop_q <= status_o.drop_hit;
    case (cmd_i.mul)
      MUL_LX, MUL_DX:   step_sq_q  <= prod;
      MUL_LY, MUL_DY:   step_sq_q  <= step_sq_q + prod;
      MUL_JUMP, MUL_SX: start_sq_q <= prod;
      MUL_SY:           start_sq_q <= start_sq_q + prod;
      default:          ;
    endcase
    if (cmd_i.load_iter) begin
      rad_q[0]  <= RAD_W'(step_sq_q);
      rad_q[1]  <= RAD_W'(start_sq_q);
      dvd_q[0]  <= DIV_W'({{2{x_q[15]}}, x_q}) + DIV_W'(KM);
      dvd_q[1]  <= DIV_W'({{2{y_q[15]}}, y_q}) + DIV_W'(KM);
      for (int i = 0; i < 2; i++) begin
        root_q[i] <= '0;
        srem_q[i] <= '0;
        drem_q[i] <= '0;
      end
    end
    if (cmd_i.load_mod) begin
      for (int i = 0; i < 2; i++) begin
        dvd_q[i]  <= dvd_q[i] + DIV_W'(MODC);
        drem_q[i] <= '0;
      end
    end
    if (cmd_i.iter) begin
      for (int i = 0; i < 2; i++) begin
        dvd_q[i]  <= {dvd_q[i][DIV_W-2:0], qbit[i]};
        drem_q[i] <= qbit[i] ? drem_n[i] - divisor : drem_n[i];
        if (!cmd_i.mod_phase) begin
          rad_q[i]  <= {rad_q[i][RAD_W-3:0], 2'b00};
          srem_q[i] <= sbit[i] ? srem_n[i] - trial[i] : srem_n[i];
          root_q[i] <= {root_q[i][ROOT_W-2:0], sbit[i]};
        end
      end
    end
    if (cmd_i.load_out) begin
      out_dropped_o             <= drop_q;
      out_distance_total_o      <= path_q;
      out_rotation_total_o      <= turn_q;
      out_farthest_from_start_o <= far_q;
      out_cells_visited_o       <= cells_q;
      out_samples_taken_o       <= samples_q;
    end
  end

  // Visited map: cleared by a walk, read in the cycle before the update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (cmd_i.update && !rd_q) begin
      mem_q[cell_addr] <= 1'b1;
    end
    if (cmd_i.mem_rd) rd_q <= mem_q[cell_addr];
  end

  assign status_o.kind     = kind_q;
  assign status_o.drop_hit = have_prev_q && (x_q == '0) && (y_q == '0) && (h_q == '0)
                             && (step_sq_q > start_sq_q);
  assign status_o.clr_last = (clr_addr_q == AW'(MAP_BITS - 1));

endmodule

@@ rtl/pts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the pose track statistics block.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_dropped_o,
  input logic [31:0] out_distance_total_o,
  input logic [31:0] out_rotation_total_o,
  input logic [16:0] out_farthest_from_start_o,
  input logic [12:0] out_cells_visited_o,
  input logic [31:0] out_samples_taken_o
);

  // One word at a time: after acceptance the input side stalls.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // An empty session shows all totals zero and cannot drop.
  a_empty_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_samples_taken_o == 32'd0) |->
      !out_dropped_o && (out_distance_total_o == 32'd0) &&
      (out_rotation_total_o == 32'd0) && (out_farthest_from_start_o == 17'd0) &&
      (out_cells_visited_o == 13'd0))
    else $error("totals nonzero in empty session");

  // Every counted sample marks at least one cell.
  a_cells_follow_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_samples_taken_o != 32'd0) |-> (out_cells_visited_o != 13'd0))
    else $error("samples counted without a visited cell");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_samples_taken_o) &&
      $stable(out_distance_total_o))
    else $error("stalled result word changed");

endmodule

bind pose_track_statistics pts_checker u_pts_checker (
  .clk_i                     (clk_i),
  .rst_ni                    (rst_ni),
  .in_valid_i                (in_valid_i),
  .in_stall_o                (in_stall_o),
  .out_valid_o               (out_valid_o),
  .out_stall_i               (out_stall_i),
  .out_dropped_o             (out_dropped_o),
  .out_distance_total_o      (out_distance_total_o),
  .out_rotation_total_o      (out_rotation_total_o),
  .out_farthest_from_start_o (out_farthest_from_start_o),
  .out_cells_visited_o       (out_cells_visited_o),
  .out_samples_taken_o       (out_samples_taken_o)
);

@@ verif/pose_track_statistics_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_track_statistics_test
// Self-checking bench for the pose track statistics block.
// ----------------------------------------------------------------------------
// A short table of directed words is followed by random pose tracks and noise,
// under several settings of the reset jump register. Every accepted word is
// run through a local model of the session statistics, and each result word
// is compared field by field with the oldest pending prediction. Both sides
// idle and stall at random; once, the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module pose_track_statistics_test;

  localparam int unsigned CELL     = pts_pkg::CELL_MM_DEF;
  localparam int unsigned SIDE     = pts_pkg::GRID_SIDE_DEF;
  localparam int unsigned N_RANDOM = 1630;
  localparam int unsigned LIMIT    = 3_000_000;
  localparam int unsigned SETTLE   = 120;
  localparam bit          KIND_POSE    = 1'b0;
  localparam bit          KIND_SESSION = 1'b1;

  typedef struct packed {
    logic        dropped;
    logic [31:0] path_len;
    logic [31:0] rot;
    logic [16:0] far;
    logic [12:0] cells;
    logic [31:0] samples;
  } stats_t;

  typedef struct {
    bit     kind;
    int     x;
    int     y;
    int     h;
    bit     typed;
    stats_t stats;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic signed [15:0] in_x = '0;
  logic signed [15:0] in_y = '0;
  logic signed [12:0] in_h = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  stats_t             out_stats;

  always #5 clk = ~clk;

  pose_track_statistics i_dut (
    .clk_i                     (clk),
    .rst_ni                    (rst_n),
    .cfg_valid_i               (cfg_valid),
    .cfg_ready_o               (cfg_ready),
    .cfg_wdata_i               (cfg_wdata),
    .in_valid_i                (in_valid),
    .in_stall_o                (in_stall),
    .in_kind_i                 (in_kind),
    .in_pos_x_i                (in_x),
    .in_pos_y_i                (in_y),
    .in_heading_i              (in_h),
    .out_valid_o               (out_valid),
    .out_stall_i               (out_stall),
    .out_dropped_o             (out_stats.dropped),
    .out_distance_total_o      (out_stats.path_len),
    .out_rotation_total_o      (out_stats.rot),
    .out_farthest_from_start_o (out_stats.far),
    .out_cells_visited_o       (out_stats.cells),
    .out_samples_taken_o       (out_stats.samples)
  );

  // Session state of the local model.
  logic [15:0] jump_mm = pts_pkg::RESET_JUMP_DEF;
  bit          has_prev;
  int          prev_x, prev_y, prev_h, origin_x, origin_y;
  logic [31:0] path_acc, turn_acc, cnt_acc;
  logic [16:0] far_acc;
  logic [12:0] cell_cnt;
  bit          cell_seen [SIDE*SIDE];

  stats_t stats_due_q[$];
  row_t   typed_rows_q[$];
  int     mismatches = 0;
  int unsigned cycles = 0;

  function automatic logic [31:0] root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic longint unsigned sq_len(int dx, int dy);
    longint ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return ax * ax + ay * ay;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int grid_cell(int c);
    int q, r;
    q = c / int'(CELL);
    if (c % int'(CELL) != 0 && c < 0) q--;
    r = q % int'(SIDE);
    if (r < 0) r += SIDE;
    return r;
  endfunction

  function automatic void clear_track();
    has_prev = 1'b0;
    prev_x = 0; prev_y = 0; prev_h = 0; origin_x = 0; origin_y = 0;
    path_acc = '0; turn_acc = '0; cnt_acc = '0; far_acc = '0; cell_cnt = '0;
    foreach (cell_seen[i]) cell_seen[i] = 1'b0;
  endfunction

  function automatic stats_t track_pose(bit kind, int x, int y, int h);
    stats_t r;
    bit drop;
    int dh, idx;
    logic [31:0] d;
    drop = 1'b0;
    if (kind == KIND_SESSION) begin
      clear_track();
    end else begin
      if (has_prev && x == 0 && y == 0 && h == 0)
        drop = sq_len(prev_x, prev_y) > longint'(jump_mm) * longint'(jump_mm);
      if (!drop) begin
        if (!has_prev) begin
          origin_x = x;
          origin_y = y;
          has_prev = 1'b1;
        end else begin
          path_acc = sat_sum(path_acc, root_floor(sq_len(x - prev_x, y - prev_y)));
          dh = h - prev_h;
          if (dh > 1800) dh -= 3600;
          if (dh < -1800) dh += 3600;
          turn_acc = sat_sum(turn_acc, dh < 0 ? -dh : dh);
        end
        prev_x = x; prev_y = y; prev_h = h;
        d = root_floor(sq_len(x - origin_x, y - origin_y));
        if (d > far_acc) far_acc = d[16:0];
        idx = grid_cell(y) * SIDE + grid_cell(x);
        if (!cell_seen[idx]) begin
          cell_seen[idx] = 1'b1;
          if (cell_cnt != 13'h1FFF) cell_cnt++;
        end
        cnt_acc = sat_sum(cnt_acc, 1);
      end
    end
    r.dropped = drop;
    r.path_len = path_acc;
    r.rot = turn_acc;
    r.far = far_acc;
    r.cells = cell_cnt;
    r.samples = cnt_acc;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial clear_track();

  // Prediction and checking share one process so both see the same edge.
  always @(posedge clk) begin
    stats_t pred;
    row_t   rw;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) jump_mm <= cfg_wdata;
      if (in_valid && !in_stall) begin
        pred = track_pose(in_kind, in_x, in_y, in_h);
        rw = typed_rows_q.pop_front();
        stats_due_q.insert(stats_due_q.size(), rw.typed ? rw.stats : pred);
      end
      if (out_valid && !out_stall) begin
        if (stats_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_stats);
        end else begin
          pred = stats_due_q.pop_front();
          if (out_stats !== pred) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", pred, out_stats);
          end
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  always @(posedge clk) begin
    int hold, quiet;
    if (cycles == 20000) hold = 600;
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else if (quiet > 0) begin
      quiet--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      quiet = $urandom_range(50, 300);
      out_stall <= 1'b0;
    end else begin
      out_stall <= pick_gap() != 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("pose_track_statistics_test NOT OK");
      $finish;
    end
  end

  task automatic send_word(bit kind, int x, int y, int h, bit typed = 1'b0,
                           stats_t stats = '0);
    row_t rw;
    int   gap;
    rw.kind = kind; rw.x = x; rw.y = y; rw.h = h; rw.typed = typed; rw.stats = stats;
    typed_rows_q.insert(typed_rows_q.size(), rw);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_x <= x[15:0];
    in_y <= y[15:0];
    in_h <= h[12:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_jump(logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    row_t table_rows[$];
    row_t rw;
    int   wx, wy, wh, sel;
    logic [15:0] jumps[4];

    // kind, x, y, heading, typed, {dropped, path, rot, far, cells, samples}
    table_rows = '{
      '{KIND_POSE, 0, 0, 0, 1'b1, '{1'b0, 32'd0, 32'd0, 17'd0, 13'd1, 32'd1}},
      '{KIND_POSE, 3000, 4000, 900, 1'b1,
        '{1'b0, 32'd5000, 32'd900, 17'd5000, 13'd2, 32'd2}},
      // Origin word after a pose beyond the jump distance is a localisation reset.
      '{KIND_POSE, 0, 0, 0, 1'b1, '{1'b1, 32'd5000, 32'd900, 17'd5000, 13'd2, 32'd2}},
      '{KIND_SESSION, 0, 0, 0, 1'b1, '{1'b0, 32'd0, 32'd0, 17'd0, 13'd0, 32'd0}},
      '{KIND_SESSION, -1, -1, -1, 1'b1, '{1'b0, 32'd0, 32'd0, 17'd0, 13'd0, 32'd0}},
      '{KIND_POSE, 32767, 32767, 3600, 1'b0, '0},
      '{KIND_POSE, -32768, -32768, -3600, 1'b0, '0},
      '{KIND_POSE, 32767, -32768, 4095, 1'b0, '0},
      '{KIND_POSE, -32768, 32767, -4096, 1'b0, '0},
      '{KIND_POSE, 0, 0, 0, 1'b0, '0},
      '{KIND_POSE, -1, -1, -1800, 1'b0, '0},
      '{KIND_POSE, -250, -251, 0, 1'b0, '0},
      '{KIND_POSE, 249, 250, 1801, 1'b0, '0},
      '{KIND_POSE, 16000, 15999, 1, 1'b0, '0},
      '{KIND_POSE, 100, 0, 0, 1'b0, '0},
      // Origin word close to the origin is kept.
      '{KIND_POSE, 0, 0, 0, 1'b0, '0},
      '{KIND_POSE, 0, 0, 1, 1'b0, '0},
      '{KIND_POSE, 1000, 0, 0, 1'b0, '0},
      '{KIND_POSE, 0, 0, 0, 1'b0, '0},
      '{KIND_POSE, 1001, 0, 0, 1'b0, '0},
      '{KIND_POSE, 0, 0, 0, 1'b0, '0}
    };
    jumps = '{16'd0, 16'hFFFF, 16'd300, 16'd0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      rw = table_rows[i];
      send_word(rw.kind, rw.x, rw.y, rw.h, rw.typed, rw.stats);
    end

    wx = 0; wy = 0; wh = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 410 == 0) begin
        write_jump(n == 410 ? 16'hFFFF : jumps[$urandom_range(0, 3)] |
                   (n == 0 ? 16'd0 : 16'($urandom_range(0, 2000))));
      end
      sel = $urandom_range(0, 199);
      if (sel < 3) begin
        send_word(KIND_SESSION, $urandom, $urandom, $urandom);
        wx = 0; wy = 0; wh = 0;
      end else if (sel < 33) begin
        send_word(KIND_POSE, 0, 0, 0);
      end else if (sel < 63) begin
        send_word(KIND_POSE, $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768, $urandom_range(0, 8191) - 4096);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          wx = $urandom_range(0, 2400) - 1200;
          wy = $urandom_range(0, 2400) - 1200;
        end
        wx += $urandom_range(0, 1200) - 600;
        wy += $urandom_range(0, 1200) - 600;
        wh += $urandom_range(0, 4000) - 2000;
        if (wx > 32767 || wx < -32768) wx = 0;
        if (wy > 32767 || wy < -32768) wy = 0;
        if (wh > 3600 || wh < -3600) wh = $urandom_range(0, 7200) - 3600;
        send_word(KIND_POSE, wx, wy, wh);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (stats_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && stats_due_q.size() == 0) begin
      $display("pose_track_statistics_test OK");
    end else begin
      $display("pose_track_statistics_test NOT OK");
    end
    $finish;
  end

endmodule
